// ===== sv/ihsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihsp_pkg
// Shared types, codes and constants of the image header size probe.
// ----------------------------------------------------------------------------
package ihsp_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned DecodeW  = 34;
    localparam int unsigned DimW     = 32;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned QueueDepthDef = 4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_WIDTH   = 3'd0,
        REG_MAX_HEIGHT  = 3'd1,
        REG_MAX_PIXELS  = 3'd2,
        REG_MAX_DECODE  = 3'd3,
        REG_MAX_FILE    = 3'd4,
        REG_SCAN_LIMIT  = 3'd5
    } t_reg_idx;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SIG    = 4'd1,
        PH_PNG    = 4'd2,
        PH_BMP    = 4'd3,
        PH_JTOP   = 4'd4,
        PH_JFILL  = 4'd5,
        PH_JLENHI = 4'd6,
        PH_JLENLO = 4'd7,
        PH_JSKIP  = 4'd8,
        PH_JSOF   = 4'd9
    } t_phase;

    // Work handed from the parser to the limit checker.
    typedef struct packed {
        logic            dims;   // 1: check width and height, 0: fixed status
        t_status         status;
        logic [DimW-1:0] width;
        logic [DimW-1:0] height;
    } t_job;

    typedef struct packed {
        t_status            status;
        logic [DimW-1:0]    width;
        logic [DimW-1:0]    height;
        logic [DecodeW-1:0] pixel_bytes;
    } t_result;

    typedef struct packed {
        logic [DimW-1:0]    max_width;
        logic [DimW-1:0]    max_height;
        logic [DimW-1:0]    max_pixels;
        logic [DecodeW-1:0] max_decode;
        logic [DimW-1:0]    max_file;
        logic [DimW-1:0]    scan_limit;
    } t_cfg;

endpackage

// ===== sv/ihsp_parser.sv =====
// ----------------------------------------------------------------------------
// ihsp_parser
// Front part: takes start and data words, tracks the file format and
// phase, and issues one job per file when the header is decided.
// ----------------------------------------------------------------------------
module ihsp_parser
    import ihsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_total_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_size, n_size;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_seg, n_seg;
    logic [7:0]  r_hdr [26];

    logic        fire;
    logic        emit;
    t_job        job;
    logic [32:0] off1;
    logic [32:0] pos1;
    logic [16:0] pay;
    logic [15:0] seglo;
    logic        m_sof;
    logic [31:0] dib;
    logic [31:0] bw;
    logic [31:0] bh;
    logic [31:0] nbh;
    logic [31:0] pw;
    logic [31:0] ph;
    logic        png_ok;

    assign o_ready = i_job_ready;
    assign fire    = i_valid && o_ready;
    assign pos1    = {1'b0, r_offset} + 33'd1;

    function automatic logic top_ok(input logic [31:0] o, input logic [31:0] sz,
                                    input logic [31:0] lim);
        logic [32:0] o1;
        begin
            o1 = {1'b0, o} + 33'd1;
            return (o1 < {1'b0, sz}) && (o < lim);
        end
    endfunction

    always_comb begin
        dib   = {r_hdr[17], r_hdr[16], r_hdr[15], r_hdr[14]};
        bw    = {r_hdr[21], r_hdr[20], r_hdr[19], r_hdr[18]};
        bh    = {i_data_byte, r_hdr[24], r_hdr[23], r_hdr[22]};
        nbh   = bh[31] ? (~bh + 32'd1) : bh;
        pw    = {r_hdr[16], r_hdr[17], r_hdr[18], r_hdr[19]};
        ph    = {r_hdr[20], r_hdr[21], r_hdr[22], i_data_byte};
        png_ok = r_hdr[0] == 8'h89 && r_hdr[1] == 8'h50 && r_hdr[2] == 8'h4E
              && r_hdr[3] == 8'h47 && r_hdr[4] == 8'h0D && r_hdr[5] == 8'h0A
              && r_hdr[6] == 8'h1A && r_hdr[7] == 8'h0A
              && {r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11]} == 32'd13
              && r_hdr[12] == 8'h49 && r_hdr[13] == 8'h48 && r_hdr[14] == 8'h44
              && r_hdr[15] == 8'h52;
        seglo = {r_seg[15:8], i_data_byte};
        pay   = {1'b0, seglo} - 17'd2;
        m_sof = r_marker >= 8'hC0 && r_marker <= 8'hCF && r_marker != 8'hC4
             && r_marker != 8'hC8 && r_marker != 8'hCC;
    end

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_size   = r_size;
        n_marker = r_marker;
        n_seg    = r_seg;
        emit     = 1'b0;
        job      = '{dims: 1'b0, status: ST_INVALID, width: '0, height: '0};
        off1     = pos1;
        if (fire && !i_command) begin
            n_size   = i_total_len;
            n_offset = '0;
            n_marker = '0;
            n_seg    = '0;
            n_phase  = PH_SIG;
            if (i_total_len == 32'd0) begin
                emit = 1'b1;
            end else if (i_total_len > i_cfg.max_file) begin
                emit = 1'b1;
                job.status = ST_LIMIT;
            end else if (i_total_len < 32'd2) begin
                emit = 1'b1;
            end
        end else if (fire && r_phase != PH_IDLE) begin
            n_offset = off1[31:0];
            unique case (r_phase)
                PH_SIG: begin
                    if (r_offset != 32'd0) begin
                        if (r_hdr[0] == 8'h89 && i_data_byte == 8'h50) begin
                            if (r_size < 32'd24) emit = 1'b1;
                            else n_phase = PH_PNG;
                        end else if (r_hdr[0] == 8'h42 && i_data_byte == 8'h4D) begin
                            if (r_size < 32'd26) emit = 1'b1;
                            else n_phase = PH_BMP;
                        end else if (r_hdr[0] == 8'hFF && i_data_byte == 8'hD8) begin
                            if (r_size < 32'd4) emit = 1'b1;
                            else if (top_ok(off1[31:0], r_size, i_cfg.scan_limit))
                                n_phase = PH_JTOP;
                            else emit = 1'b1;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
                PH_PNG: begin
                    if (r_offset == 32'd23) begin
                        emit = 1'b1;
                        if (png_ok) begin
                            job.dims = 1'b1;
                            job.width = pw;
                            job.height = ph;
                        end
                    end
                end
                PH_BMP: begin
                    if (r_offset == 32'd25) begin
                        emit = 1'b1;
                        if (dib == 32'd12) begin
                            job.dims = 1'b1;
                            job.width = {16'd0, r_hdr[19], r_hdr[18]};
                            job.height = {16'd0, r_hdr[21], r_hdr[20]};
                        end else if (dib >= 32'd40 && bw != 32'd0 && !bw[31]
                                     && bh != 32'h8000_0000) begin
                            job.dims = 1'b1;
                            job.width = bw;
                            job.height = nbh;
                        end
                    end
                end
                PH_JTOP: begin
                    if (i_data_byte == 8'hFF) n_phase = PH_JFILL;
                    else if (!top_ok(off1[31:0], r_size, i_cfg.scan_limit)) emit = 1'b1;
                end
                PH_JFILL: begin
                    if (i_data_byte == 8'hFF && off1[31:0] < r_size) begin
                        n_phase = PH_JFILL;
                    end else if (i_data_byte == 8'h00 || i_data_byte == 8'hD8
                                 || i_data_byte == 8'h01
                                 || (i_data_byte >= 8'hD0 && i_data_byte <= 8'hD7)) begin
                        if (top_ok(off1[31:0], r_size, i_cfg.scan_limit)) n_phase = PH_JTOP;
                        else emit = 1'b1;
                    end else if (i_data_byte == 8'hD9 || i_data_byte == 8'hDA) begin
                        emit = 1'b1;
                    end else if (off1 + 33'd2 > {1'b0, r_size}) begin
                        emit = 1'b1;
                    end else begin
                        n_marker = i_data_byte;
                        n_phase  = PH_JLENHI;
                    end
                end
                PH_JLENHI: begin
                    n_seg   = {i_data_byte, 8'd0};
                    n_phase = PH_JLENLO;
                end
                PH_JLENLO: begin
                    n_seg = seglo;
                    if (seglo < 16'd2) begin
                        emit = 1'b1;
                    end else if ({17'd0, pay} > {2'b0, r_size} - {2'b0, off1[31:0]}
                                 || {1'b0, off1} + {17'd0, pay} >
                                    {2'b0, i_cfg.scan_limit}) begin
                        emit = 1'b1;
                    end else if (m_sof) begin
                        if (pay < 17'd5) emit = 1'b1;
                        else begin
                            n_seg   = 16'd5;
                            n_phase = PH_JSOF;
                        end
                    end else if (pay == 17'd0) begin
                        if (top_ok(off1[31:0], r_size, i_cfg.scan_limit)) n_phase = PH_JTOP;
                        else emit = 1'b1;
                    end else begin
                        n_seg   = pay[15:0];
                        n_phase = PH_JSKIP;
                    end
                end
                PH_JSKIP: begin
                    n_seg = r_seg - 16'd1;
                    if (r_seg == 16'd1) begin
                        if (top_ok(off1[31:0], r_size, i_cfg.scan_limit)) n_phase = PH_JTOP;
                        else emit = 1'b1;
                    end
                end
                PH_JSOF: begin
                    n_seg = r_seg - 16'd1;
                    if (r_seg == 16'd1) begin
                        emit = 1'b1;
                        job.dims = 1'b1;
                        job.width = {16'd0, r_hdr[3], i_data_byte};
                        job.height = {16'd0, r_hdr[1], r_hdr[2]};
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        if (emit) n_phase = PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_offset <= '0;
            r_size   <= '0;
            r_marker <= '0;
            r_seg    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_size   <= n_size;
            r_marker <= n_marker;
            r_seg    <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_command) begin
            if (r_phase == PH_SIG) begin
                r_hdr[{4'd0, r_offset[0]}] <= i_data_byte;
            end else if ((r_phase == PH_PNG || r_phase == PH_BMP) && r_offset < 32'd26) begin
                r_hdr[r_offset[4:0]] <= i_data_byte;
            end else if (r_phase == PH_JSOF && r_seg <= 16'd5 && r_seg != 16'd0) begin
                r_hdr[5'(16'd5 - r_seg)] <= i_data_byte;
            end
        end
    end

    assign o_job_valid = fire && emit;
    assign o_job       = job;

endmodule

// ===== sv/ihsp_queue.sv =====
// ----------------------------------------------------------------------------
// ihsp_queue
// Short job queue between the parser and the limit checker.
// ----------------------------------------------------------------------------
module ihsp_queue
    import ihsp_pkg::*;
#(
    parameter int unsigned Depth = QueueDepthDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_job            r_mem [Depth];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(Depth - 1)) ? '0 : r_wr + AW'(1);
            if (pop)  r_rd <= (r_rd == AW'(Depth - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== sv/ihsp_checker.sv =====
// ----------------------------------------------------------------------------
// ihsp_checker
// Back part: checks dimensions against the limits in two stages and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module ihsp_checker
    import ihsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_job    i_job,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    // Stage one: product register.
    logic        r_s1_v;
    t_job        r_s1_job;
    logic        r_s1_pre;  // early decided status valid
    t_status     r_s1_st;
    logic [63:0] r_s1_px;
    logic        r_out_v;
    t_result     r_out;
    logic        s1_adv, out_adv;
    logic [63:0] px;
    t_status     pre_st;
    logic        pre;
    t_result     res;

    assign out_adv = !r_out_v || i_ready;
    assign s1_adv  = !r_s1_v || out_adv;
    assign o_ready = s1_adv;
    assign px      = i_job.width * i_job.height;

    always_comb begin
        pre = 1'b1;
        pre_st = i_job.status;
        if (i_job.dims) begin
            if (i_job.width == '0 || i_job.height == '0) pre_st = ST_INVALID;
            else if (i_job.width > i_cfg.max_width || i_job.height > i_cfg.max_height)
                pre_st = ST_LIMIT;
            else pre = 1'b0;
        end
    end

    always_comb begin
        res = '{status: r_s1_st, width: '0, height: '0, pixel_bytes: '0};
        if (!r_s1_pre) begin
            if (r_s1_px > {32'd0, i_cfg.max_pixels}
                || r_s1_px > {32'd0, i_cfg.max_decode[DecodeW-1:2]}) begin
                res.status = ST_LIMIT;
            end else begin
                res.status      = ST_OK;
                res.width       = r_s1_job.width;
                res.height      = r_s1_job.height;
                res.pixel_bytes = {r_s1_px[31:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_job <= i_job;
            r_s1_pre <= pre;
            r_s1_st  <= pre_st;
            r_s1_px  <= px;
        end
        if (out_adv) r_out <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_adv)  r_s1_v  <= i_valid;
            if (out_adv) r_out_v <= r_s1_v;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// ===== sv/image_header_size_probe.sv =====
// Throughput: one word per cycle; the parser state updates once per data byte.
// The job queue and a two-stage limit checker let output stalls back up
// without losing words; the input stalls only when the queue is full.
// Reset: synchronous, active low; limits return to defaults, no file is open.
// ----------------------------------------------------------------------------
// image_header_size_probe
// Finds the pixel size of a PNG, BMP or JPEG file from its byte stream.
// ----------------------------------------------------------------------------
module image_header_size_probe
    import ihsp_pkg::*;
#(
    parameter int unsigned QueueDepth = QueueDepthDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // total_len[31:0], data_byte[39:32]
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // status, width, height, pixel_bytes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [33:0]  i_cfg_data
);

    t_cfg    r_cfg;
    logic    jv, jr, qv, qr;
    t_job    job, qjob;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_width  <= 32'd4096;
            r_cfg.max_height <= 32'd4096;
            r_cfg.max_pixels <= 32'd16777216;
            r_cfg.max_decode <= 34'd67108864;
            r_cfg.max_file   <= 32'd16777216;
            r_cfg.scan_limit <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_WIDTH:  r_cfg.max_width  <= i_cfg_data[31:0];
                REG_MAX_HEIGHT: r_cfg.max_height <= i_cfg_data[31:0];
                REG_MAX_PIXELS: r_cfg.max_pixels <= i_cfg_data[31:0];
                REG_MAX_DECODE: r_cfg.max_decode <= i_cfg_data;
                REG_MAX_FILE:   r_cfg.max_file   <= i_cfg_data[31:0];
                REG_SCAN_LIMIT: r_cfg.scan_limit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    ihsp_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_command(s_axis_tuser), .i_total_len(s_axis_tdata[31:0]),
        .i_data_byte(s_axis_tdata[39:32]),
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    ihsp_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(jv), .o_ready(jr), .i_job(job),
        .o_valid(qv), .i_ready(qr), .o_job(qjob)
    );

    ihsp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(qv), .o_ready(qr), .i_job(qjob),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res)
    );

    assign m_axis_tdata = {4'd0, res.pixel_bytes, res.height, res.width, res.status};

`ifndef ASSERT_OFF
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_OK |-> m_axis_tdata[33:2] != 32'd0)
        else $error("ok result with zero width");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[99:2] == '0)
        else $error("failed result carries dimensions");
    a_no_full_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jv |-> jr)
        else $error("job issued while queue full");
`endif

endmodule

// ===== test/image_header_size_probe_tb.sv =====
// ----------------------------------------------------------------------------
// image_header_size_probe_tb
// Streams PNG, BMP and JPEG files through the probe under several limit
// settings and random stalls on both sides. Every result word is compared
// field by field with a built-in parser model of the probe.
// ----------------------------------------------------------------------------
module image_header_size_probe_tb;
    import ihsp_pkg::*;

    localparam int unsigned IdleLimit = 5000;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_STATUS} t_row_kind;

    typedef struct {
        bit        cmd;
        logic [31:0] size;
        logic [7:0]  b;
        t_row_kind   kind;
        t_status     st;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [33:0]  i_cfg_data;

    image_header_size_probe dut (.*);

    // Limits as the probe holds them.
    logic [63:0] lim_width, lim_height, lim_pixels, lim_decode, lim_file, lim_scan;
    // Parser state of the model.
    logic [31:0] par_off, par_size;
    t_phase      par_phase;
    logic [7:0]  par_hdr[26];
    logic [7:0]  par_marker;
    logic [15:0] par_seg;
    bit          par_done;
    bit          dim_hit;
    t_result     dim_res;

    t_result     pending_sizes[$];
    logic [7:0]  file_bytes[$];
    int          errors;
    int          words_sent;
    int          idle_cycles = 0;
    int          hold_cycles = 0;
    int          ready_mode = 0;
    int          mode_cycles = 0;
    bit          no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void close_file(t_status s, logic [31:0] w, logic [31:0] h,
                                       logic [33:0] d);
        dim_hit = 1'b1;
        dim_res = '{status: s, width: w, height: h, pixel_bytes: d};
        par_done = 1'b1;
        par_phase = PH_IDLE;
    endfunction

    function automatic void reject(t_status s);
        close_file(s, '0, '0, '0);
    endfunction

    function automatic void judge_dims(logic [63:0] w, logic [63:0] h);
        logic [63:0] px;
        if (w == 0 || h == 0) begin
            reject(ST_INVALID);
        end else if (w > lim_width || h > lim_height) begin
            reject(ST_LIMIT);
        end else begin
            px = w * h;
            if (px > lim_pixels || px > lim_decode / 4) reject(ST_LIMIT);
            else close_file(ST_OK, w[31:0], h[31:0], 34'(px * 4));
        end
    endfunction

    function automatic logic [31:0] hdr_be32(int i);
        return {par_hdr[i], par_hdr[i+1], par_hdr[i+2], par_hdr[i+3]};
    endfunction

    function automatic logic [31:0] hdr_le32(int i);
        return {par_hdr[i+3], par_hdr[i+2], par_hdr[i+1], par_hdr[i]};
    endfunction

    function automatic void jpeg_resume();
        if (64'(par_off) + 1 < 64'(par_size) && 64'(par_off) < lim_scan) par_phase = PH_JTOP;
        else reject(ST_INVALID);
    endfunction

    function automatic void signature_done();
        if (par_hdr[0] == 8'h89 && par_hdr[1] == 8'h50) begin
            if (par_size < 24) reject(ST_INVALID);
            else par_phase = PH_PNG;
        end else if (par_hdr[0] == 8'h42 && par_hdr[1] == 8'h4D) begin
            if (par_size < 26) reject(ST_INVALID);
            else par_phase = PH_BMP;
        end else if (par_hdr[0] == 8'hFF && par_hdr[1] == 8'hD8) begin
            if (par_size < 4) reject(ST_INVALID);
            else jpeg_resume();
        end else begin
            reject(ST_INVALID);
        end
    endfunction

    function automatic void png_done();
        logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        logic [7:0] tag[4] = '{8'h49, 8'h48, 8'h44, 8'h52};
        bit good;
        good = 1'b1;
        for (int i = 0; i < 8; i++) if (par_hdr[i] != sig[i]) good = 1'b0;
        if (hdr_be32(8) != 32'd13) good = 1'b0;
        for (int i = 0; i < 4; i++) if (par_hdr[12+i] != tag[i]) good = 1'b0;
        if (good) judge_dims(64'(hdr_be32(16)), 64'(hdr_be32(20)));
        else reject(ST_INVALID);
    endfunction

    function automatic void bmp_done();
        logic [31:0] dib, w, h;
        dib = hdr_le32(14);
        w = hdr_le32(18);
        h = hdr_le32(22);
        if (dib == 32'd12) begin
            judge_dims(64'({par_hdr[19], par_hdr[18]}), 64'({par_hdr[21], par_hdr[20]}));
        end else if (dib >= 32'd40) begin
            if (w == 0 || w[31] || h == 32'h8000_0000) reject(ST_INVALID);
            else judge_dims(64'(w), 64'(h[31] ? 32'(-h) : h));
        end else begin
            reject(ST_INVALID);
        end
    endfunction

    function automatic void jpeg_marker_seen(logic [7:0] m);
        if (m == 8'h00 || m == 8'hD8 || m == 8'h01 || (m >= 8'hD0 && m <= 8'hD7)) begin
            jpeg_resume();
        end else if (m == 8'hD9 || m == 8'hDA) begin
            reject(ST_INVALID);
        end else if (64'(par_off) + 2 > 64'(par_size)) begin
            reject(ST_INVALID);
        end else begin
            par_marker = m;
            par_phase = PH_JLENHI;
        end
    endfunction

    function automatic void jpeg_length_seen();
        logic [63:0] pay;
        bit sof;
        sof = par_marker >= 8'hC0 && par_marker <= 8'hCF && par_marker != 8'hC4
              && par_marker != 8'hC8 && par_marker != 8'hCC;
        pay = 64'(par_seg) - 2;
        if (par_seg < 2) begin
            reject(ST_INVALID);
        end else if (pay > 64'(par_size) - 64'(par_off) || 64'(par_off) + pay > lim_scan) begin
            reject(ST_INVALID);
        end else if (sof) begin
            if (pay < 5) begin
                reject(ST_INVALID);
            end else begin
                par_seg = 16'd5;
                par_phase = PH_JSOF;
            end
        end else if (pay == 0) begin
            jpeg_resume();
        end else begin
            par_seg = 16'(pay);
            par_phase = PH_JSKIP;
        end
    endfunction

    // Advances the model by one input word; dim_hit tells whether it closed a file.
    function automatic void parse_word(bit cmd, logic [31:0] size, logic [7:0] b);
        logic [31:0] pos;
        dim_hit = 1'b0;
        if (!cmd) begin
            par_size = size;
            par_off = '0;
            par_marker = '0;
            par_seg = '0;
            par_done = 1'b0;
            par_phase = PH_SIG;
            if (size == 0) reject(ST_INVALID);
            else if (64'(size) > lim_file) reject(ST_LIMIT);
            else if (size < 2) reject(ST_INVALID);
            return;
        end
        if (par_done || par_phase == PH_IDLE) return;
        pos = par_off;
        par_off = pos + 1;
        case (par_phase)
            PH_SIG: begin
                par_hdr[pos[0]] = b;
                if (pos >= 1) signature_done();
            end
            PH_PNG: begin
                if (pos < 24) par_hdr[pos] = b;
                if (par_off >= 24) png_done();
            end
            PH_BMP: begin
                if (pos < 26) par_hdr[pos] = b;
                if (par_off >= 26) bmp_done();
            end
            PH_JTOP: begin
                if (b != 8'hFF) jpeg_resume();
                else par_phase = PH_JFILL;
            end
            PH_JFILL: begin
                if (!(b == 8'hFF && par_off < par_size)) jpeg_marker_seen(b);
            end
            PH_JLENHI: begin
                par_seg = {b, 8'h00};
                par_phase = PH_JLENLO;
            end
            PH_JLENLO: begin
                par_seg = par_seg | 16'(b);
                jpeg_length_seen();
            end
            PH_JSKIP: begin
                par_seg = par_seg - 1;
                if (par_seg == 0) jpeg_resume();
            end
            PH_JSOF: begin
                par_hdr[(5 - par_seg) % 5] = b;
                par_seg = par_seg - 1;
                if (par_seg == 0) begin
                    judge_dims(64'({par_hdr[3], par_hdr[4]}), 64'({par_hdr[1], par_hdr[2]}));
                end
            end
            default: begin
                par_phase = PH_IDLE;
                par_done = 1'b1;
            end
        endcase
    endfunction

    task automatic pause_input();
        int r, gap;
        r = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one word and returns at the edge that accepts it; tvalid stays high.
    task automatic send_word(input bit cmd, input logic [31:0] size, input logic [7:0] b,
                             input t_row_kind kind, input t_status st);
        pause_input();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, cmd ? 32'($urandom) : size};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        words_sent++;
        parse_word(cmd, size, b);
        if (kind == ROW_STATUS) pending_sizes.push_back('{st, '0, '0, '0});
        else if (kind == ROW_PRED && dim_hit) pending_sizes.push_back(dim_res);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sizes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [63:0] v[6]);
        t_reg_idx regs[6] = '{REG_MAX_WIDTH, REG_MAX_HEIGHT, REG_MAX_PIXELS,
                              REG_MAX_DECODE, REG_MAX_FILE, REG_SCAN_LIMIT};
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= 34'(v[i]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        lim_width  = 64'(v[0][31:0]);
        lim_height = 64'(v[1][31:0]);
        lim_pixels = 64'(v[2][31:0]);
        lim_decode = 64'(v[3][33:0]);
        lim_file   = 64'(v[4][31:0]);
        lim_scan   = 64'(v[5][31:0]);
    endtask

    function automatic logic [31:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return 32'd1;
        if (r < 70) return $urandom_range(1, 5000);
        if (r < 75) return '1;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_dim16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return 16'hFFFF;
        return 16'($urandom_range(1, 5000));
    endfunction

    function automatic void push_be32(logic [31:0] v);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void build_png();
        logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        foreach (sig[i]) file_bytes.push_back(sig[i]);
        push_be32($urandom_range(0, 9) == 0 ? 32'($urandom_range(0, 20)) : 32'd13);
        push_be32($urandom_range(0, 9) == 0 ? 32'h4948_4453 : 32'h4948_4452);
        push_be32(pick_dim());
        push_be32(pick_dim());
        if ($urandom_range(0, 19) == 0) file_bytes[$urandom_range(2, 7)] = 8'($urandom);
    endfunction

    function automatic void build_bmp();
        int r;
        logic [31:0] h;
        file_bytes.push_back(8'h42);
        file_bytes.push_back(8'h4D);
        repeat (12) file_bytes.push_back(8'($urandom));
        r = $urandom_range(0, 9);
        if (r < 3) begin
            push_le32(32'd12);
            push_le32({pick_dim16(), pick_dim16()});
            push_le32($urandom);
        end else begin
            push_le32(r < 6 ? 32'd40 : r < 8 ? 32'd124 : r < 9 ? $urandom_range(0, 39)
                                                               : $urandom);
            push_le32($urandom_range(0, 9) == 0 ? $urandom : pick_dim());
            h = pick_dim();
            r = $urandom_range(0, 9);
            push_le32(r < 3 ? 32'(-h) : r == 3 ? 32'h8000_0000 : h);
        end
    endfunction

    function automatic void build_jpeg();
        int len, r;
        logic [7:0] m;
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hD8);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 7) == 0) file_bytes.push_back(8'($urandom_range(0, 254)));
            repeat ($urandom_range(1, 3)) file_bytes.push_back(8'hFF);
            r = $urandom_range(0, 19);
            if (r < 3) begin
                m = r == 0 ? 8'h00 : r == 1 ? 8'h01 : 8'($urandom_range(8'hD0, 8'hD7));
                file_bytes.push_back(m);
            end else if (r == 3) begin
                file_bytes.push_back($urandom_range(0, 1) ? 8'hD9 : 8'hDA);
            end else begin
                m = r == 4 ? 8'hC4 : r == 5 ? 8'hDB : 8'($urandom_range(8'hE0, 8'hEF));
                len = $urandom_range(0, 15) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 12);
                file_bytes.push_back(m);
                file_bytes.push_back(8'(len >> 8));
                file_bytes.push_back(8'(len));
                repeat (len > 2 ? len - 2 : 0) file_bytes.push_back(8'($urandom));
            end
        end
        file_bytes.push_back(8'hFF);
        r = $urandom_range(0, 15);
        file_bytes.push_back(r == 0 ? 8'($urandom_range(8'hC0, 8'hCF))
                           : r == 1 ? 8'hCC : 8'($urandom_range(0, 1) ? 8'hC0 : 8'hC2));
        len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(7, 17);
        file_bytes.push_back(8'(len >> 8));
        file_bytes.push_back(8'(len));
        file_bytes.push_back(8'h08);
        begin
            logic [15:0] w, h;
            h = pick_dim16();
            w = pick_dim16();
            file_bytes.push_back(h[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(w[7:0]);
        end
        repeat (len > 7 ? len - 7 : 0) file_bytes.push_back(8'($urandom));
    endfunction

    task automatic send_random_file();
        int r, n;
        logic [31:0] size;
        file_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 30) build_png();
        else if (r < 55) build_bmp();
        else if (r < 88) build_jpeg();
        else repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
        n = file_bytes.size();
        r = $urandom_range(0, 99);
        if (r < 75) size = n + $urandom_range(0, 8);
        else if (r < 92) size = $urandom_range(2, n);
        else size = $urandom;
        if ($urandom_range(0, 19) == 0) send_word(1'b1, '0, 8'($urandom), ROW_PRED, ST_OK);
        send_word(1'b0, size, 8'($urandom), ROW_PRED, ST_OK);
        foreach (file_bytes[i]) send_word(1'b1, '0, file_bytes[i], ROW_PRED, ST_OK);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            no_gaps = $urandom_range(0, 4) == 0;
            send_random_file();
        end
        no_gaps = 1'b0;
    endtask

    // Output side: the stall pattern is picked anew at random from time to time.
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(50, 300);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (ready_mode == 1) begin
            m_axis_tready <= $urandom_range(0, 3) != 0;
        end else if (ready_mode == 2 && $urandom_range(0, 19) == 0) begin
            hold_cycles <= $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sizes.size() == 0) begin
                note_mismatch($sformatf("result word with nothing expected: %h", m_axis_tdata));
            end else begin
                want = pending_sizes.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            m_axis_tdata[1:0], want.status));
                if (m_axis_tdata[33:2] != want.width)
                    note_mismatch($sformatf("width %0d, expected %0d",
                                            m_axis_tdata[33:2], want.width));
                if (m_axis_tdata[65:34] != want.height)
                    note_mismatch($sformatf("height %0d, expected %0d",
                                            m_axis_tdata[65:34], want.height));
                if (m_axis_tdata[99:66] != want.pixel_bytes)
                    note_mismatch($sformatf("pixel_bytes %0d, expected %0d",
                                            m_axis_tdata[99:66], want.pixel_bytes));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row rows[] = '{
            '{1'b1, 32'd0,  8'hA5, ROW_NONE,   ST_OK},
            '{1'b0, 32'd0,  8'h00, ROW_STATUS, ST_INVALID},
            '{1'b0, '1,     8'hFF, ROW_STATUS, ST_LIMIT},
            '{1'b0, 32'd1,  8'h00, ROW_STATUS, ST_INVALID},
            '{1'b1, 32'd0,  8'hFF, ROW_NONE,   ST_OK},
            '{1'b0, 32'd10, 8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h89, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h50, ROW_STATUS, ST_INVALID},
            '{1'b0, 32'd20, 8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h42, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h4D, ROW_STATUS, ST_INVALID},
            '{1'b0, 32'd3,  8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'hFF, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'hD8, ROW_STATUS, ST_INVALID},
            '{1'b0, 32'd4,  8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'hFF, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'hD8, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h00, ROW_STATUS, ST_INVALID},
            '{1'b0, 32'd50, 8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h47, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h49, ROW_STATUS, ST_INVALID},
            '{1'b0, 32'd99, 8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h89, ROW_PRED,   ST_OK},
            '{1'b0, 32'd2,  8'h00, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h42, ROW_PRED,   ST_OK},
            '{1'b1, 32'd0,  8'h4D, ROW_STATUS, ST_INVALID}
        };
        logic [63:0] v[6];

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MAX_WIDTH;
        i_cfg_data = '0;
        errors = 0;
        words_sent = 0;
        no_gaps = 1'b0;
        lim_width = 4096;
        lim_height = 4096;
        lim_pixels = 16777216;
        lim_decode = 67108864;
        lim_file = 16777216;
        lim_scan = 65536;
        par_off = '0;
        par_size = '0;
        par_phase = PH_IDLE;
        par_marker = '0;
        par_seg = '0;
        par_done = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].cmd, rows[i].size, rows[i].b, rows[i].kind, rows[i].st);
        run_random(350);

        wait_idle();
        v = '{64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h3_FFFF_FFFF,
              64'hFFFF_FFFF, 64'hFFFF_FFFF};
        write_limits(v);
        run_random(400);

        wait_idle();
        v = '{64'd1, 64'd1, 64'd1, 64'd4, 64'd1, 64'd4};
        write_limits(v);
        run_random(60);

        wait_idle();
        v = '{64'd1, 64'd1, 64'd1, 64'd4, 64'hFFFF_FFFF, 64'd4};
        write_limits(v);
        run_random(150);

        for (int p = 0; p < 3; p++) begin
            wait_idle();
            v = '{$urandom_range(1, 6000), $urandom_range(1, 6000),
                  $urandom_range(1, 30000000), 64'($urandom_range(4, 120000000)),
                  $urandom_range(20, 300), $urandom_range(4, 80)};
            write_limits(v);
            run_random(250);
        end

        wait_idle();
        v = '{64'd4096, 64'd4096, 64'd16777216, 64'd67108864, 64'd16777216, 64'd65536};
        write_limits(v);
        run_random(100);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_sizes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
